/* rtl/core/sector_cache_lru_lock_macros.svh */
// assertion macros for the sector cache directory
// used by the top level; expects clk and rst_n in scope
`ifndef SECTOR_CACHE_LRU_LOCK_MACROS_SVH
`define SECTOR_CACHE_LRU_LOCK_MACROS_SVH
`ifndef ASSERT_OFF
`define SCL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SCL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SCL_ASSERT_IMP(lbl, ante, cons)
`define SCL_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/sclru_pkg.sv */
// shared types and constants of the sector cache directory
// no dependencies
`default_nettype none
package sclru_pkg;

  localparam int ADDR_BITS   = 24;
  localparam int OFFSET_BITS = 7;
  localparam int TAG_BITS    = ADDR_BITS - OFFSET_BITS;
  localparam int OUT_SEC_W   = 3;

  localparam logic [1:0] OP_LOCK  = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_FLUSH = 2'd2;

  typedef struct packed {
    logic [1:0]           operation;
    logic [ADDR_BITS-1:0] address;
  } in_t;

  typedef struct packed {
    logic                 success;
    logic [OUT_SEC_W-1:0] sector;
    logic                 hit;
  } out_t;

  typedef struct packed {
    logic init;
    logic shift;
    logic put_front;
  } lru_ctl_t;

endpackage
`default_nettype wire

/* rtl/core/sclru_lru.sv */
// lru stack of sector indices, mru at position 0
// depends on sclru_pkg
`default_nettype none
module sclru_lru
  import sclru_pkg::*;
#(
  parameter int NUM_SECTORS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire lru_ctl_t                       ctl,
  input  wire logic [$clog2(NUM_SECTORS)-1:0] rd_idx,
  input  wire logic [$clog2(NUM_SECTORS)-1:0] wr_idx,
  input  wire logic [$clog2(NUM_SECTORS)-1:0] wr_sel,
  output logic      [$clog2(NUM_SECTORS)-1:0] rd_data
);

  localparam int SEC_W = $clog2(NUM_SECTORS);

  logic [SEC_W-1:0] order_r [NUM_SECTORS];

  assign rd_data = order_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.init) begin
      for (int p = 0; p < NUM_SECTORS; p++) begin
        order_r[p] <= SEC_W'(NUM_SECTORS - 1 - p);
      end
    end else if (ctl.put_front) begin
      order_r[0] <= wr_sel;
    end else if (ctl.shift) begin
      order_r[wr_idx] <= rd_data;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/sector_cache_lru_lock.sv */
// channel   ports                      transfer when
// input     start, busy, in_data       start high and busy low
// result    out_strobe, out_data       out_strobe high (one cycle, no stall)
//
// free, flush and unused codes: result in the cycle after the input transfer
// lock: tag search, then lru scan (miss) or position search (hit), then stack
//   shift unless every sector is locked (failed result); one shared comparator
// busy is high from a lock transfer until its result strobe
// synchronous reset restores the flushed directory
// depends on sclru_pkg, sclru_lru and sector_cache_lru_lock_macros.svh
`default_nettype none
`include "sector_cache_lru_lock_macros.svh"
module sector_cache_lru_lock
  import sclru_pkg::*;
#(
  parameter int NUM_SECTORS = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_strobe,
  output out_t      out_data
);

  localparam int SEC_W = $clog2(NUM_SECTORS);
  localparam logic [SEC_W-1:0] LAST = SEC_W'(NUM_SECTORS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_TAG   = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_FIND  = 3'd3;
  localparam logic [2:0] ST_SHIFT = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [SEC_W-1:0]    idx_r, idx_nxt;
  logic [SEC_W-1:0]    sel_r, sel_nxt;
  logic                hit_r, hit_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic                strobe_r, strobe_nxt;
  out_t                out_r, out_nxt;

  logic [TAG_BITS-1:0]    tags_r [NUM_SECTORS];
  logic [NUM_SECTORS-1:0] lock_r;

  lru_ctl_t            lru_ctl;
  logic [SEC_W-1:0]    lru_rd_idx;
  logic [SEC_W-1:0]    lru_rd;
  logic [TAG_BITS-1:0] cmp_a, cmp_b;
  logic                cmp_eq;
  logic                tag_we, lock_set, lock_free, flush;
  logic [31:0]         sel_ext;

  sclru_lru #(
    .NUM_SECTORS(NUM_SECTORS)
  ) u_lru (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lru_ctl),
    .rd_idx (lru_rd_idx),
    .wr_idx (idx_r),
    .wr_sel (sel_r),
    .rd_data(lru_rd)
  );

  assign lru_rd_idx = (state_r == ST_SHIFT) ? idx_r - SEC_W'(1) : idx_r;

  // shared comparator: tag search or stack position search
  assign cmp_a  = (state_r == ST_TAG) ? tags_r[idx_r] : TAG_BITS'(lru_rd);
  assign cmp_b  = (state_r == ST_TAG) ? tag_r : TAG_BITS'(sel_r);
  assign cmp_eq = (cmp_a == cmp_b);

  assign sel_ext = 32'(sel_r);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    sel_nxt    = sel_r;
    hit_nxt    = hit_r;
    tag_nxt    = tag_r;
    strobe_nxt = 1'b0;
    out_nxt    = out_r;
    lru_ctl    = '0;
    tag_we     = 1'b0;
    lock_set   = 1'b0;
    lock_free  = 1'b0;
    flush      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          tag_nxt = in_data.address[ADDR_BITS-1:OFFSET_BITS];
          hit_nxt = 1'b0;
          idx_nxt = '0;
          out_nxt = '0;
          case (in_data.operation)
            OP_LOCK: begin
              state_nxt = ST_TAG;
            end
            OP_FREE: begin
              lock_free       = 1'b1;
              strobe_nxt      = 1'b1;
              out_nxt.success = 1'b1;
            end
            OP_FLUSH: begin
              flush           = 1'b1;
              lru_ctl.init    = 1'b1;
              strobe_nxt      = 1'b1;
              out_nxt.success = 1'b1;
            end
            default: begin
              strobe_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_TAG: begin
        if (cmp_eq) begin
          sel_nxt   = idx_r;
          hit_nxt   = 1'b1;
          idx_nxt   = '0;
          state_nxt = ST_FIND;
        end else if (idx_r == LAST) begin
          state_nxt = ST_SCAN;
        end else begin
          idx_nxt = idx_r + SEC_W'(1);
        end
      end
      ST_SCAN: begin
        if (!lock_r[lru_rd]) begin
          sel_nxt   = lru_rd;
          state_nxt = ST_SHIFT;
        end else if (idx_r == '0) begin
          strobe_nxt = 1'b1;
          out_nxt    = '0;
          state_nxt  = ST_IDLE;
        end else begin
          idx_nxt = idx_r - SEC_W'(1);
        end
      end
      ST_FIND: begin
        if (cmp_eq) begin
          state_nxt = ST_SHIFT;
        end else begin
          idx_nxt = idx_r + SEC_W'(1);
        end
      end
      ST_SHIFT: begin
        if (idx_r == '0) begin
          lru_ctl.put_front = 1'b1;
          lock_set          = 1'b1;
          tag_we            = !hit_r;
          strobe_nxt        = 1'b1;
          out_nxt.success   = 1'b1;
          out_nxt.sector    = sel_ext[OUT_SEC_W-1:0];
          out_nxt.hit       = hit_r;
          state_nxt         = ST_IDLE;
        end else begin
          lru_ctl.shift = 1'b1;
          idx_nxt       = idx_r - SEC_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    sel_r <= sel_nxt;
    hit_r <= hit_nxt;
    tag_r <= tag_nxt;
    out_r <= out_nxt;
  end

  // directory tags and lock bits
  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      lock_r <= '0;
      for (int s = 0; s < NUM_SECTORS; s++) begin
        tags_r[s] <= '1;
      end
    end else begin
      if (lock_free) begin
        lock_r <= '0;
      end else if (lock_set) begin
        lock_r[sel_r] <= 1'b1;
      end
      if (tag_we) begin
        tags_r[sel_r] <= tag_r;
      end
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = strobe_r;
  assign out_data   = out_r;

  `SCL_ASSERT_IMP(a_strobe_idle, out_strobe, !busy)
  `SCL_ASSERT_NXT(a_lock_busy, start && !busy && in_data.operation == OP_LOCK, busy)
  `SCL_ASSERT_NXT(a_quick_result, start && !busy && in_data.operation != OP_LOCK, out_strobe)
  `SCL_ASSERT_IMP(a_hit_success, out_strobe && out_data.hit, out_data.success)

endmodule
`default_nettype wire
